// ===== hdl/assert_macros.svh =====
// Assertion helpers shared by the RTL. Bodies compile away under SYNTHESIS.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_IMPLIES(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);
`define ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);
`else
`define ASSERT_IMPLIES(lbl, ante, cons, msg)
`define ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

// ===== hdl/lds_pkg.sv =====
package lds_pkg;

    localparam int CMD_W      = 2;
    localparam int IDX_W      = 5;
    localparam int MASK_W     = 32;
    localparam int CFG_W      = 6;
    localparam int MAX_BLOCKS = 32;

    localparam logic [CFG_W-1:0] BLOCKS_USED_RST = 6'd32;

    typedef enum logic [CMD_W-1:0] {
        CMD_INSTR = 2'd0,
        CMD_EDGE  = 2'd1,
        CMD_SOLVE = 2'd2,
        CMD_CLEAR = 2'd3
    } cmd_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ROW,
        ST_HEAD,
        ST_SCAN,
        ST_LAST,
        ST_EMIT_RD,
        ST_EMIT_LD
    } state_t;

endpackage

// ===== hdl/liveness_dataflow_solver.sv =====
// Channel   Direction  Signals
// s_        in         s_valid/s_ready, command, block index, successor, used and defined masks
// m_        out        m_valid/m_ready, block index, live-out mask, last flag
// cfg_      in         cfg_valid/cfg_ready, blocks in use
//
// Instruction, edge and clear items: one per cycle; the node or successor memory is read
// in the transfer cycle and written back in the cycle after, the last write forwarded.
// Solve: each sweep walks the n blocks in use, its pace set by the single node
// memory read port (one successor per cycle); sweeps repeat until nothing grows, then
// n results leave at one per cycle unless the receiver stalls, the first after a read state.
// Reset and clear act at once through per-entry valid bits; no clearing pass.
// A stalled result holds; new items are taken only between solves.
`include "assert_macros.svh"

module liveness_dataflow_solver #(
    parameter int NUM_BLOCKS = 32,
    parameter int REG_COUNT  = 32
) (
    input  logic        aclk,
    input  logic        aresetn,

    input  logic        s_valid,
    output logic        s_ready,
    input  logic [1:0]  s_command,
    input  logic [4:0]  s_block_index,
    input  logic [4:0]  s_succ_block,
    input  logic [31:0] s_used_regs,
    input  logic [31:0] s_defined_regs,

    output logic        m_valid,
    input  logic        m_ready,
    output logic [4:0]  m_out_block,
    output logic [31:0] m_live_out_regs,
    output logic        m_last_block,

    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [5:0]  cfg_data
);

    localparam int TB = (NUM_BLOCKS < lds_pkg::MAX_BLOCKS) ? NUM_BLOCKS : lds_pkg::MAX_BLOCKS;
    localparam int RW = (REG_COUNT < lds_pkg::MASK_W) ? REG_COUNT : lds_pkg::MASK_W;
    localparam int AW = $clog2(TB);
    localparam int NW = 3 * RW;
    localparam int IW = lds_pkg::IDX_W;
    localparam int MW = lds_pkg::MASK_W;

    // node word: live-out, kill, upward-exposed
    lds_pkg::state_t state_reg, state_next;

    logic [lds_pkg::CFG_W-1:0] blocks_used_reg;

    logic          p_valid_reg;
    lds_pkg::cmd_t p_cmd_reg;
    logic [AW-1:0] p_addr_reg;
    logic [AW-1:0] p_succ_reg;
    logic [RW-1:0] p_used_reg;
    logic [RW-1:0] p_defd_reg;

    logic          fwd_node_reg, fwd_succ_reg;
    logic [NW-1:0] last_node_reg;
    logic [TB-1:0] last_succ_reg;

    logic [TB-1:0] ek_vld_reg, live_vld_reg, succ_vld_reg;
    logic          node_rv_ek_reg, node_rv_live_reg, succ_rv_reg;

    logic [AW-1:0] b_reg, b_next;
    logic [AW-1:0] m_reg, m_next;
    logic [AW-1:0] nl_reg, nl_next;
    logic [AW-1:0] rd_m_reg, rd_m_next;
    logic          rd_v_reg, rd_v_next;
    logic [TB-1:0] row_reg, row_next;
    logic [RW-1:0] acc_reg, acc_next;
    logic [RW-1:0] lb_reg, lb_next;
    logic [RW-1:0] exp_b_reg, exp_b_next;
    logic [RW-1:0] kill_b_reg, kill_b_next;
    logic          changed_reg, changed_next;

    logic          m_valid_reg;
    logic [IW-1:0] m_block_reg;
    logic [MW-1:0] m_live_reg;
    logic          m_last_reg;

    lds_pkg::cmd_t cmd_in;
    logic          s_fire, blk_ok, suc_ok, ld_instr, ld_edge, clear_all, solve_start;
    logic [AW-1:0] nl_calc;

    logic          node_re, node_we;
    logic [AW-1:0] node_raddr, node_waddr;
    logic [NW-1:0] node_wdata, node_q, node_cur;
    logic          succ_re, succ_we;
    logic [AW-1:0] succ_raddr;
    logic [TB-1:0] succ_wdata, succ_q, succ_cur;

    logic [RW-1:0] exp_cur, kill_cur, live_cur, contrib, acc_upd;
    logic [RW-1:0] new_exp, new_kill;
    logic          take, out_free, out_load, out_last;

    assign cmd_in    = lds_pkg::cmd_t'(s_command);
    assign s_ready   = (state_reg == lds_pkg::ST_IDLE);
    assign s_fire    = s_valid && s_ready;
    assign blk_ok    = (int'(s_block_index) < TB);
    assign suc_ok    = (int'(s_succ_block) < TB);
    assign ld_instr  = s_fire && (cmd_in == lds_pkg::CMD_INSTR) && blk_ok;
    assign ld_edge   = s_fire && (cmd_in == lds_pkg::CMD_EDGE) && blk_ok && suc_ok;
    assign clear_all = s_fire && (cmd_in == lds_pkg::CMD_CLEAR);
    assign solve_start = s_fire && (cmd_in == lds_pkg::CMD_SOLVE);
    assign cfg_ready = 1'b1;

    always_comb begin
        if (blocks_used_reg == '0) begin
            nl_calc = '0;
        end else if (int'(blocks_used_reg) > TB) begin
            nl_calc = AW'(TB - 1);
        end else begin
            nl_calc = AW'(blocks_used_reg - 6'd1);
        end
    end

    lds_ram #(.WIDTH(NW), .DEPTH(TB)) u_node_ram (
        .aclk  (aclk),
        .we    (node_we),
        .waddr (node_waddr),
        .wdata (node_wdata),
        .re    (node_re),
        .raddr (node_raddr),
        .rdata (node_q)
    );

    lds_ram #(.WIDTH(TB), .DEPTH(TB)) u_succ_ram (
        .aclk  (aclk),
        .we    (succ_we),
        .waddr (p_addr_reg),
        .wdata (succ_wdata),
        .re    (succ_re),
        .raddr (succ_raddr),
        .rdata (succ_q)
    );

    // entries never written since reset or clear read as zero
    always_comb begin
        if (fwd_node_reg) begin
            node_cur = last_node_reg;
        end else begin
            node_cur[RW-1:0]      = node_rv_ek_reg ? node_q[RW-1:0] : '0;
            node_cur[2*RW-1:RW]   = node_rv_ek_reg ? node_q[2*RW-1:RW] : '0;
            node_cur[NW-1:2*RW]   = node_rv_live_reg ? node_q[NW-1:2*RW] : '0;
        end
        if (fwd_succ_reg) begin
            succ_cur = last_succ_reg;
        end else begin
            succ_cur = succ_rv_reg ? succ_q : '0;
        end
    end

    assign exp_cur  = node_cur[RW-1:0];
    assign kill_cur = node_cur[2*RW-1:RW];
    assign live_cur = node_cur[NW-1:2*RW];
    assign contrib  = exp_cur | (live_cur & ~kill_cur);
    assign take     = rd_v_reg && row_reg[rd_m_reg];
    assign acc_upd  = take ? (acc_reg | contrib) : acc_reg;
    assign new_exp  = exp_cur | (p_used_reg & ~kill_cur);
    assign new_kill = kill_cur | p_defd_reg;
    assign succ_wdata = succ_cur | ({{(TB-1){1'b0}}, 1'b1} << p_succ_reg);
    assign succ_we  = p_valid_reg && (p_cmd_reg == lds_pkg::CMD_EDGE);
    assign out_free = !m_valid_reg || m_ready;
    assign out_last = (b_reg == nl_reg);

    always_comb begin
        state_next   = state_reg;
        b_next       = b_reg;
        m_next       = m_reg;
        nl_next      = nl_reg;
        rd_m_next    = rd_m_reg;
        rd_v_next    = 1'b0;
        row_next     = row_reg;
        acc_next     = acc_reg;
        lb_next      = lb_reg;
        exp_b_next   = exp_b_reg;
        kill_b_next  = kill_b_reg;
        changed_next = changed_reg;
        out_load     = 1'b0;

        node_re    = 1'b0;
        node_raddr = b_reg;
        node_we    = p_valid_reg && (p_cmd_reg == lds_pkg::CMD_INSTR);
        node_waddr = p_addr_reg;
        node_wdata = {live_cur, new_kill, new_exp};
        succ_re    = 1'b0;
        succ_raddr = b_reg;

        unique case (state_reg)
            lds_pkg::ST_IDLE: begin
                node_re    = ld_instr;
                succ_re    = ld_edge;
                node_raddr = s_block_index[AW-1:0];
                succ_raddr = s_block_index[AW-1:0];
                if (clear_all) begin
                    changed_next = 1'b0;
                end
                if (solve_start) begin
                    nl_next      = nl_calc;
                    b_next       = '0;
                    changed_next = 1'b0;
                    state_next   = lds_pkg::ST_ROW;
                end
            end
            lds_pkg::ST_ROW: begin
                node_re    = 1'b1;
                succ_re    = 1'b1;
                state_next = lds_pkg::ST_HEAD;
            end
            lds_pkg::ST_HEAD: begin
                row_next    = succ_cur;
                acc_next    = live_cur;
                lb_next     = live_cur;
                exp_b_next  = exp_cur;
                kill_b_next = kill_cur;
                node_re     = 1'b1;
                node_raddr  = '0;
                rd_v_next   = 1'b1;
                rd_m_next   = '0;
                m_next      = AW'(1);
                state_next  = (nl_reg == '0) ? lds_pkg::ST_LAST : lds_pkg::ST_SCAN;
            end
            lds_pkg::ST_SCAN: begin
                acc_next   = acc_upd;
                node_re    = 1'b1;
                node_raddr = m_reg;
                rd_v_next  = 1'b1;
                rd_m_next  = m_reg;
                if (m_reg == nl_reg) begin
                    state_next = lds_pkg::ST_LAST;
                end else begin
                    m_next = m_reg + 1'b1;
                end
            end
            lds_pkg::ST_LAST: begin
                node_we      = 1'b1;
                node_waddr   = b_reg;
                node_wdata   = {acc_upd, kill_b_reg, exp_b_reg};
                changed_next = changed_reg || (acc_upd != lb_reg);
                if (b_reg != nl_reg) begin
                    b_next     = b_reg + 1'b1;
                    state_next = lds_pkg::ST_ROW;
                end else if (changed_next) begin
                    // another sweep
                    b_next       = '0;
                    changed_next = 1'b0;
                    state_next   = lds_pkg::ST_ROW;
                end else begin
                    b_next     = '0;
                    state_next = lds_pkg::ST_EMIT_RD;
                end
            end
            lds_pkg::ST_EMIT_RD: begin
                node_re    = 1'b1;
                state_next = lds_pkg::ST_EMIT_LD;
            end
            lds_pkg::ST_EMIT_LD: begin
                if (out_free) begin
                    out_load = 1'b1;
                    if (out_last) begin
                        state_next = lds_pkg::ST_IDLE;
                    end else begin
                        b_next     = b_reg + 1'b1;
                        node_re    = 1'b1;
                        node_raddr = b_reg + 1'b1;
                    end
                end
            end
            default: begin
                state_next = lds_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= lds_pkg::ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            blocks_used_reg <= lds_pkg::BLOCKS_USED_RST;
        end else if (cfg_valid) begin
            blocks_used_reg <= cfg_data;
        end
    end

    // load stage: write-back in the cycle after the transfer
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p_valid_reg  <= 1'b0;
            fwd_node_reg <= 1'b0;
            fwd_succ_reg <= 1'b0;
        end else begin
            p_valid_reg  <= ld_instr || ld_edge;
            fwd_node_reg <= ld_instr && node_we && (node_waddr == s_block_index[AW-1:0]);
            fwd_succ_reg <= ld_edge && succ_we && (p_addr_reg == s_block_index[AW-1:0]);
        end
    end

    always_ff @(posedge aclk) begin
        if (s_fire) begin
            p_cmd_reg  <= cmd_in;
            p_addr_reg <= s_block_index[AW-1:0];
            p_succ_reg <= s_succ_block[AW-1:0];
            p_used_reg <= s_used_regs[RW-1:0];
            p_defd_reg <= s_defined_regs[RW-1:0];
        end
        if (node_we) begin
            last_node_reg <= node_wdata;
        end
        if (succ_we) begin
            last_succ_reg <= succ_wdata;
        end
        if (node_re) begin
            node_rv_ek_reg   <= ek_vld_reg[node_raddr];
            node_rv_live_reg <= live_vld_reg[node_raddr];
        end
        if (succ_re) begin
            succ_rv_reg <= succ_vld_reg[succ_raddr];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ek_vld_reg   <= '0;
            live_vld_reg <= '0;
            succ_vld_reg <= '0;
        end else begin
            if (node_we) begin
                ek_vld_reg[node_waddr]   <= 1'b1;
                live_vld_reg[node_waddr] <= 1'b1;
            end
            if (succ_we) begin
                succ_vld_reg[p_addr_reg] <= 1'b1;
            end
            // drop live-out sets at the start of a solve, everything on clear
            if (solve_start) begin
                live_vld_reg <= '0;
            end
            if (clear_all) begin
                ek_vld_reg   <= '0;
                live_vld_reg <= '0;
                succ_vld_reg <= '0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rd_v_reg    <= 1'b0;
            changed_reg <= 1'b0;
        end else begin
            rd_v_reg    <= rd_v_next;
            changed_reg <= changed_next;
        end
    end

    always_ff @(posedge aclk) begin
        b_reg      <= b_next;
        m_reg      <= m_next;
        nl_reg     <= nl_next;
        rd_m_reg   <= rd_m_next;
        row_reg    <= row_next;
        acc_reg    <= acc_next;
        lb_reg     <= lb_next;
        exp_b_reg  <= exp_b_next;
        kill_b_reg <= kill_b_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (out_load) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            m_block_reg <= IW'(b_reg);
            m_live_reg  <= MW'(live_cur);
            m_last_reg  <= out_last;
        end
    end

    assign m_valid         = m_valid_reg;
    assign m_out_block     = m_block_reg;
    assign m_live_out_regs = m_live_reg;
    assign m_last_block    = m_last_reg;

    `ASSERT_IMPLIES(a_stage_after_idle, p_valid_reg, $past(state_reg) == lds_pkg::ST_IDLE, "load write-back outside idle")
    `ASSERT_IMPLIES(a_fwd_needs_stage, fwd_node_reg, p_valid_reg && p_cmd_reg == lds_pkg::CMD_INSTR, "node forward without instruction write-back")
    `ASSERT_IMPLIES(a_solve_no_collide, node_we && node_re && state_reg != lds_pkg::ST_IDLE, node_waddr != node_raddr, "node read and write collide during solve")
    `ASSERT_NEXT(a_clear_empties, clear_all, ek_vld_reg == '0 && succ_vld_reg == '0 && live_vld_reg == '0, "tables not emptied by clear")

endmodule

// ===== hdl/lds_ram.sv =====
module lds_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             aclk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== test/testbench.sv =====
module testbench;
    import lds_pkg::*;

    localparam int          SETTLE_CYCLES = 8;
    localparam int          TARGET_ITEMS  = 230;
    localparam int unsigned CYCLE_LIMIT   = 2000000;

    typedef enum logic [1:0] {
        OP_ITEM,
        OP_CFG,
        OP_DRAIN
    } op_kind_t;

    typedef struct packed {
        op_kind_t    kind;
        cmd_t        command;
        logic [4:0]  blk;
        logic [4:0]  succ;
        logic [31:0] used;
        logic [31:0] defd;
        logic [5:0]  cfg;
        logic [4:0]  gap;
    } stim_t;

    typedef struct packed {
        logic [4:0]  blk;
        logic [31:0] live;
        logic        last;
    } live_out_t;

    logic        aclk;
    logic        aresetn = 1'b0;

    logic        s_valid = 1'b0;
    logic        s_ready;
    logic [1:0]  s_command = '0;
    logic [4:0]  s_block_index = '0;
    logic [4:0]  s_succ_block = '0;
    logic [31:0] s_used_regs = '0;
    logic [31:0] s_defined_regs = '0;

    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [4:0]  m_out_block;
    logic [31:0] m_live_out_regs;
    logic        m_last_block;

    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [5:0]  cfg_data = '0;

    // predicted block state
    logic [31:0] exposed_tab [MAX_BLOCKS];
    logic [31:0] kill_tab    [MAX_BLOCKS];
    logic [31:0] succ_tab    [MAX_BLOCKS];
    logic [31:0] live_tab    [MAX_BLOCKS];
    logic [5:0]  blocks_cfg = BLOCKS_USED_RST;

    stim_t       stim_q [$];
    live_out_t   live_out_q [$];

    stim_t       cur = '0;
    bit          drv_busy = 1'b0;
    bit          offer;
    bit          cfg_offer;
    logic [4:0]  gap_left = '0;
    int          settle = 0;
    bit          calm = 1'b0;
    int          item_total = 0;

    int          rx_wait = 0;
    int          rx_count = 0;
    int          mismatches = 0;
    int unsigned cycles = 0;

    liveness_dataflow_solver u_dut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_command       (s_command),
        .s_block_index   (s_block_index),
        .s_succ_block    (s_succ_block),
        .s_used_regs     (s_used_regs),
        .s_defined_regs  (s_defined_regs),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_out_block     (m_out_block),
        .m_live_out_regs (m_live_out_regs),
        .m_last_block    (m_last_block),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_data        (cfg_data)
    );

    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    initial begin
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
    end

    initial begin
        for (int i = 0; i < MAX_BLOCKS; i++) begin
            exposed_tab[i] = '0;
            kill_tab[i]    = '0;
            succ_tab[i]    = '0;
            live_tab[i]    = '0;
        end
    end

    function automatic void push_op(op_kind_t kind, cmd_t command, int blk, int succ,
                                    logic [31:0] used, logic [31:0] defd, int cfg);
        stim_t op;
        op.kind    = kind;
        op.command = command;
        op.blk     = blk[4:0];
        op.succ    = succ[4:0];
        op.used    = used;
        op.defd    = defd;
        op.cfg     = cfg[5:0];
        op.gap     = (kind == OP_ITEM && !calm) ? 5'($urandom_range(0, 16)) : 5'd0;
        if (kind == OP_ITEM)
            item_total++;
        stim_q.push_back(op);
    endfunction

    function automatic logic [31:0] rand_mask();
        case ($urandom_range(0, 5))
            0: return '0;
            1: return '1;
            2: return 32'd1 << $urandom_range(0, 31);
            3: return $urandom;
            default: return $urandom & $urandom & $urandom;
        endcase
    endfunction

    // Sweep in index order until no live-out set grows, then queue one result per block.
    task automatic solve_liveness();
        int          n;
        bit          grew;
        logic [31:0] acc;
        live_out_t   res;
        n = (blocks_cfg == 0) ? 1 : ((blocks_cfg > MAX_BLOCKS) ? MAX_BLOCKS : int'(blocks_cfg));
        for (int b = 0; b < n; b++)
            live_tab[b] = '0;
        do begin
            grew = 1'b0;
            for (int b = 0; b < n; b++) begin
                acc = live_tab[b];
                for (int m = 0; m < n; m++) begin
                    if (succ_tab[b][m])
                        acc |= exposed_tab[m] | (live_tab[m] & ~kill_tab[m]);
                end
                if (acc != live_tab[b]) begin
                    live_tab[b] = acc;
                    grew = 1'b1;
                end
            end
        end while (grew);
        for (int b = 0; b < n; b++) begin
            res.blk  = b[4:0];
            res.live = live_tab[b];
            res.last = (b == n - 1);
            live_out_q.push_back(res);
        end
    endtask

    task automatic absorb_item(stim_t it);
        case (it.command)
            CMD_INSTR: begin
                exposed_tab[it.blk] |= it.used & ~kill_tab[it.blk];
                kill_tab[it.blk]    |= it.defd;
            end
            CMD_EDGE: succ_tab[it.blk][it.succ] = 1'b1;
            CMD_SOLVE: solve_liveness();
            default: begin
                for (int i = 0; i < MAX_BLOCKS; i++) begin
                    exposed_tab[i] = '0;
                    kill_tab[i]    = '0;
                    succ_tab[i]    = '0;
                    live_tab[i]    = '0;
                end
            end
        endcase
    endtask

    // Stimulus: directed graph first, then random graphs under changing block counts.
    initial begin
        int n;
        int nb;
        int bi;
        int si;

        push_op(OP_ITEM, CMD_INSTR, 0, 0, 32'hFFFF_FFFF, 32'h0, 0);
        push_op(OP_ITEM, CMD_INSTR, 31, 31, 32'h0, 32'hFFFF_FFFF, 0);
        push_op(OP_ITEM, CMD_INSTR, 31, 0, 32'hFFFF_0000, 32'h0, 0);
        push_op(OP_ITEM, CMD_INSTR, 1, 0, 32'h0000_00F0, 32'h0000_000F, 0);
        push_op(OP_ITEM, CMD_INSTR, 1, 0, 32'h0000_000F, 32'h0, 0);
        push_op(OP_ITEM, CMD_INSTR, 2, 0, 32'h0000_0A00, 32'h0000_0A00, 0);
        push_op(OP_ITEM, CMD_EDGE, 0, 1, 32'h0, 32'h0, 0);
        push_op(OP_ITEM, CMD_EDGE, 0, 1, 32'h0, 32'h0, 0);
        push_op(OP_ITEM, CMD_EDGE, 31, 31, 32'h0, 32'h0, 0);
        push_op(OP_ITEM, CMD_EDGE, 30, 31, 32'h0, 32'h0, 0);
        push_op(OP_ITEM, CMD_EDGE, 1, 2, 32'h0, 32'h0, 0);
        push_op(OP_ITEM, CMD_EDGE, 2, 0, 32'h0, 32'h0, 0);
        push_op(OP_ITEM, CMD_EDGE, 31, 0, 32'h0, 32'h0, 0);
        push_op(OP_ITEM, CMD_SOLVE, 0, 0, 32'h0, 32'h0, 0);
        // offered while the receiver holds off
        push_op(OP_ITEM, CMD_INSTR, 3, 0, 32'h0000_0001, 32'h0, 0);
        push_op(OP_ITEM, CMD_EDGE, 3, 2, 32'h0, 32'h0, 0);
        push_op(OP_CFG, CMD_INSTR, 0, 0, 32'h0, 32'h0, 0);
        push_op(OP_ITEM, CMD_SOLVE, 0, 0, 32'h0, 32'h0, 0);
        push_op(OP_CFG, CMD_INSTR, 0, 0, 32'h0, 32'h0, 2);
        push_op(OP_ITEM, CMD_EDGE, 1, 5, 32'h0, 32'h0, 0);
        push_op(OP_ITEM, CMD_EDGE, 0, 31, 32'h0, 32'h0, 0);
        push_op(OP_ITEM, CMD_SOLVE, 0, 0, 32'h0, 32'h0, 0);
        push_op(OP_CFG, CMD_INSTR, 0, 0, 32'h0, 32'h0, 63);
        push_op(OP_ITEM, CMD_CLEAR, 0, 0, 32'h0, 32'h0, 0);
        push_op(OP_ITEM, CMD_SOLVE, 0, 0, 32'h0, 32'h0, 0);

        while (item_total < TARGET_ITEMS) begin
            case ($urandom_range(0, 9))
                0: nb = 0;
                1: nb = $urandom_range(33, 63);
                2: nb = 32;
                default: nb = $urandom_range(1, 12);
            endcase
            push_op(OP_CFG, CMD_INSTR, 0, 0, 32'h0, 32'h0, nb);
            n = (nb == 0) ? 1 : ((nb > 32) ? 32 : nb);
            calm = ($urandom_range(0, 3) == 0);
            if ($urandom_range(0, 2) == 0)
                push_op(OP_ITEM, CMD_CLEAR, $urandom_range(0, 31), $urandom_range(0, 31),
                        rand_mask(), rand_mask(), 0);
            repeat ($urandom_range(n, 2 * n + 2)) begin
                bi = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 31) : $urandom_range(0, n - 1);
                if ($urandom_range(0, 1) == 0) begin
                    push_op(OP_ITEM, CMD_INSTR, bi, $urandom_range(0, 31),
                            rand_mask(), rand_mask(), 0);
                end else begin
                    case ($urandom_range(0, 7))
                        0: si = $urandom_range(0, 31);
                        1, 2, 3: si = (bi + 1) % n;
                        default: si = $urandom_range(0, n - 1);
                    endcase
                    push_op(OP_ITEM, CMD_EDGE, bi, si, rand_mask(), rand_mask(), 0);
                end
            end
            push_op(OP_ITEM, CMD_SOLVE, $urandom_range(0, 31), $urandom_range(0, 31),
                    rand_mask(), rand_mask(), 0);
            repeat ($urandom_range(0, 3))
                push_op(OP_ITEM, cmd_t'($urandom_range(0, 3)), $urandom_range(0, 31),
                        $urandom_range(0, 31), rand_mask(), rand_mask(), 0);
            if ($urandom_range(0, 3) == 0)
                push_op(OP_DRAIN, CMD_INSTR, 0, 0, 32'h0, 32'h0, 0);
        end

        do @(posedge aclk);
        while (stim_q.size() != 0 || drv_busy || s_valid || cfg_valid);
        while (live_out_q.size() != 0)
            @(posedge aclk);
        repeat (20) @(posedge aclk);
        if (mismatches == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

    // Driver: one queued operation at a time; register writes and drains wait for quiet.
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid   <= 1'b0;
            cfg_valid <= 1'b0;
        end else begin
            offer     = s_valid;
            cfg_offer = cfg_valid;
            if (s_valid && s_ready) begin
                absorb_item(cur);
                offer    = 1'b0;
                drv_busy = 1'b0;
            end
            if (cfg_valid && cfg_ready) begin
                blocks_cfg = cur.cfg;
                cfg_offer  = 1'b0;
                drv_busy   = 1'b0;
            end
            if (!drv_busy && stim_q.size() != 0) begin
                cur      = stim_q.pop_front();
                drv_busy = 1'b1;
                gap_left = cur.gap;
                settle   = 0;
            end
            if (drv_busy && !offer && !cfg_offer) begin
                if (cur.kind == OP_ITEM) begin
                    if (gap_left != 0)
                        gap_left--;
                    else
                        offer = 1'b1;
                end else if (live_out_q.size() != 0) begin
                    settle = 0;
                end else if (settle < SETTLE_CYCLES) begin
                    settle++;
                end else if (cur.kind == OP_CFG) begin
                    cfg_offer = 1'b1;
                end else begin
                    drv_busy = 1'b0;
                end
            end
            s_valid        <= offer;
            s_command      <= cur.command;
            s_block_index  <= cur.blk;
            s_succ_block   <= cur.succ;
            s_used_regs    <= cur.used;
            s_defined_regs <= cur.defd;
            cfg_valid      <= cfg_offer;
            cfg_data       <= cur.cfg;
        end
    end

    // Receiver: random stall per transfer, stall-free stretches, one long hold early on.
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                rx_count++;
                rx_wait = ((rx_count / 48) % 2 == 1) ? 0 : $urandom_range(0, 16);
                if (rx_count == 10)
                    rx_wait = 400;
            end else if (rx_wait > 0) begin
                rx_wait--;
            end
            m_ready <= (rx_wait == 0);
        end
    end

    always @(posedge aclk) begin
        live_out_t want;
        if (aresetn && m_valid && m_ready) begin
            if (live_out_q.size() == 0) begin
                $display("%0t: unexpected result, block %0d live %h last %0d", $time,
                         m_out_block, m_live_out_regs, m_last_block);
                mismatches++;
            end else begin
                want = live_out_q.pop_front();
                if (m_out_block !== want.blk) begin
                    $display("%0t: out_block expected %0d actual %0d", $time,
                             want.blk, m_out_block);
                    mismatches++;
                end
                if (m_live_out_regs !== want.live) begin
                    $display("%0t: live_out_regs of block %0d expected %h actual %h", $time,
                             want.blk, want.live, m_live_out_regs);
                    mismatches++;
                end
                if (m_last_block !== want.last) begin
                    $display("%0t: last_block of block %0d expected %0d actual %0d", $time,
                             want.blk, want.last, m_last_block);
                    mismatches++;
                end
            end
        end
    end

    always @(posedge aclk) begin
        cycles++;
        if (cycles >= CYCLE_LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

endmodule

// ===== liveness_dataflow_solver.f =====
+incdir+hdl
hdl/lds_pkg.sv
hdl/lds_ram.sv
hdl/liveness_dataflow_solver.sv
test/testbench.sv
